>>> src/ovl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ovl_pkg
// Shared types, codes and constants of the overvoltage alert and lockout core.
// ---------------------------------------------------------------------------
package ovl_pkg;

	// Event codes carried in the input beat's tuser
	typedef enum logic [1:0] {
		CMD_CHECK = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_ACK   = 2'd2,
		CMD_RESET = 2'd3
	} cmd_t;

	// Safety states
	typedef enum logic [1:0] {
		MODE_SAFE    = 2'd0,
		MODE_DANGER  = 2'd1,
		MODE_LOCKOUT = 2'd2,
		MODE_WARNING = 2'd3
	} mode_t;

	// Alert levels
	localparam logic [1:0] LVL_NONE   = 2'd0;
	localparam logic [1:0] LVL_LOW    = 2'd1;
	localparam logic [1:0] LVL_MEDIUM = 2'd2;
	localparam logic [1:0] LVL_HIGH   = 2'd3;

	// Register indexes (byte address is four times the index)
	localparam logic [2:0] REG_HIGH_THR   = 3'd0;
	localparam logic [2:0] REG_MEDIUM_THR = 3'd1;
	localparam logic [2:0] REG_LOW_THR    = 3'd2;
	localparam logic [2:0] REG_LOCKOUT    = 3'd3;
	localparam logic [2:0] REG_FLASH_FAST = 3'd4;
	localparam logic [2:0] REG_FLASH_MED  = 3'd5;
	localparam logic [2:0] REG_FLASH_SLOW = 3'd6;
	localparam logic [2:0] REG_ENABLE     = 3'd7;

	// Enable mask bits
	localparam int EN_SOUND = 0;
	localparam int EN_LED   = 1;
	localparam int EN_LOCK  = 2;

	// Register reset values
	localparam logic signed [15:0] HIGH_THR_RST   = 16'sd2000;
	localparam logic signed [15:0] MEDIUM_THR_RST = 16'sd1500;
	localparam logic signed [15:0] LOW_THR_RST    = 16'sd1300;
	localparam logic [23:0]        LOCKOUT_RST    = 24'd30000;
	localparam logic [15:0]        FLASH_FAST_RST = 16'd100;
	localparam logic [15:0]        FLASH_MED_RST  = 16'd250;
	localparam logic [15:0]        FLASH_SLOW_RST = 16'd500;
	localparam logic [2:0]         ENABLE_RST     = 3'd7;

	// Beep duration in ticks
	localparam logic [15:0] BEEP_TICKS = 16'd500;

	typedef struct packed {
		logic signed [15:0] high_thr;
		logic signed [15:0] medium_thr;
		logic signed [15:0] low_thr;
		logic [23:0]        lockout_ticks;
		logic [15:0]        flash_fast;
		logic [15:0]        flash_medium;
		logic [15:0]        flash_slow;
		logic [2:0]         enable_mask;
	} cfg_t;

	typedef struct packed {
		mode_t              mode;
		logic [1:0]         level;
		logic signed [15:0] last_voltage;
		logic [23:0]        lockout_remaining;
		logic [7:0]         danger_counter;
		logic               ack_flag;
		logic               flash_active;
		logic [15:0]        flash_elapsed;
		logic [15:0]        flash_period;
		logic               led_level;
		logic               beep_active;
		logic [15:0]        beep_elapsed;
	} state_t;

	typedef struct packed {
		logic               acknowledged;
		logic signed [15:0] held_voltage;
		logic [7:0]         danger_total;
		logic               beep_on;
		logic               red_led;
		logic               awaiting_ack;
		logic               can_proceed;
		logic               locked_out;
		logic               ac_danger;
		logic [1:0]         safety_state;
		logic [1:0]         alert_level;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

>>> src/ovl_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ovl_step
// Next-state and result logic for one event beat.
// ---------------------------------------------------------------------------
module ovl_step (
	input  ovl_pkg::cfg_t          cfg,
	input  ovl_pkg::state_t        cur,
	input  ovl_pkg::cmd_t          cmd,
	input  logic signed [15:0]     voltage,
	output ovl_pkg::state_t        nxt,
	output ovl_pkg::result_t       res
);

	logic [1:0]  lvl;
	logic [15:0] flash_inc;
	logic        locked;

	// Grade the voltage against the thresholds
	always_comb begin
		if (voltage > cfg.high_thr) begin
			lvl = ovl_pkg::LVL_HIGH;
		end else if (voltage > cfg.medium_thr) begin
			lvl = ovl_pkg::LVL_MEDIUM;
		end else if (voltage > cfg.low_thr) begin
			lvl = ovl_pkg::LVL_LOW;
		end else begin
			lvl = ovl_pkg::LVL_NONE;
		end
	end

	assign flash_inc = cur.flash_elapsed + 16'd1;

	// Apply the event, then the lockout release
	always_comb begin
		nxt = cur;
		case (cmd)
			ovl_pkg::CMD_CHECK: begin
				nxt.last_voltage = voltage;
				nxt.level        = lvl;
				if (lvl != ovl_pkg::LVL_NONE) begin
					nxt.mode = ovl_pkg::MODE_DANGER;
					if (cur.danger_counter != 8'hFF) begin
						nxt.danger_counter = cur.danger_counter + 8'd1;
					end
					if (cfg.enable_mask[ovl_pkg::EN_LED]) begin
						case (lvl)
							ovl_pkg::LVL_HIGH:   nxt.flash_period = cfg.flash_fast;
							ovl_pkg::LVL_MEDIUM: nxt.flash_period = cfg.flash_medium;
							default:             nxt.flash_period = cfg.flash_slow;
						endcase
						nxt.flash_active  = 1'b1;
						nxt.flash_elapsed = '0;
						nxt.led_level     = 1'b1;
					end
					if (cfg.enable_mask[ovl_pkg::EN_SOUND]) begin
						nxt.beep_active  = 1'b1;
						nxt.beep_elapsed = '0;
					end
					if (lvl == ovl_pkg::LVL_HIGH && cfg.enable_mask[ovl_pkg::EN_LOCK]) begin
						nxt.mode              = ovl_pkg::MODE_LOCKOUT;
						nxt.lockout_remaining = cfg.lockout_ticks;
						nxt.danger_counter    = '0;
						nxt.flash_active      = 1'b0;
						nxt.beep_active       = 1'b0;
						nxt.led_level         = 1'b0;
					end
				end
			end
			ovl_pkg::CMD_TICK: begin
				if (cur.flash_active) begin
					if (flash_inc >= cur.flash_period) begin
						nxt.flash_elapsed = '0;
						nxt.led_level     = ~cur.led_level;
					end else begin
						nxt.flash_elapsed = flash_inc;
					end
				end
				if (cur.beep_active) begin
					if (cur.beep_elapsed != 16'hFFFF) begin
						nxt.beep_elapsed = cur.beep_elapsed + 16'd1;
					end
					if (nxt.beep_elapsed >= ovl_pkg::BEEP_TICKS) begin
						nxt.beep_active = 1'b0;
					end
				end
				if (cur.lockout_remaining != '0) begin
					nxt.lockout_remaining = cur.lockout_remaining - 24'd1;
				end
			end
			ovl_pkg::CMD_ACK: begin
				nxt.ack_flag     = 1'b1;
				nxt.flash_active = 1'b0;
				nxt.beep_active  = 1'b0;
				nxt.led_level    = 1'b0;
				if (cur.mode == ovl_pkg::MODE_LOCKOUT) begin
					nxt.mode = ovl_pkg::MODE_WARNING;
				end
			end
			default: begin
				nxt.mode              = ovl_pkg::MODE_SAFE;
				nxt.level             = ovl_pkg::LVL_NONE;
				nxt.last_voltage      = '0;
				nxt.lockout_remaining = '0;
				nxt.danger_counter    = '0;
				nxt.ack_flag          = 1'b0;
				nxt.flash_active      = 1'b0;
				nxt.beep_active       = 1'b0;
				nxt.led_level         = 1'b0;
			end
		endcase
		// release an expired, acknowledged lockout
		if (nxt.mode == ovl_pkg::MODE_LOCKOUT && nxt.lockout_remaining == '0
				&& nxt.ack_flag) begin
			nxt.mode     = ovl_pkg::MODE_SAFE;
			nxt.ack_flag = 1'b0;
		end
	end

	// Build the result from the updated state
	assign locked = (nxt.mode == ovl_pkg::MODE_LOCKOUT);

	always_comb begin
		res.alert_level  = nxt.level;
		res.safety_state = nxt.mode;
		res.ac_danger    = (nxt.last_voltage >= cfg.medium_thr);
		res.locked_out   = locked;
		res.can_proceed  = ~locked & ~(nxt.mode == ovl_pkg::MODE_DANGER & ~nxt.ack_flag);
		res.awaiting_ack = locked & (nxt.lockout_remaining == '0) & ~nxt.ack_flag;
		res.red_led      = nxt.led_level;
		res.beep_on      = nxt.beep_active;
		res.danger_total = nxt.danger_counter;
		res.held_voltage = nxt.last_voltage;
		res.acknowledged = nxt.ack_flag;
	end

endmodule

>>> src/overvoltage_alert_lockout_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// overvoltage_alert_lockout_core
// Grades voltage checks, drives LED and beep alerts and runs the lockout timer.
// ---------------------------------------------------------------------------
// An accepted input beat passes through the input register, then the
// result register; the state update sits between the two.
// Throughput: one event per cycle unless the result side stalls the pipeline.
// Reset: arst_n clears all control state and loads the register defaults;
// the input is ready (s_tready high) as soon as reset is released.
module overvoltage_alert_lockout_core (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] voltage
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] alert_level, [3:2] safety_state, [4] ac_danger, [5] locked_out,
	// [6] can_proceed, [7] awaiting_ack, [8] red_led, [9] beep_on,
	// [17:10] danger_total, [33:18] held_voltage, [34] acknowledged, rest zero
	output logic [ovl_pkg::TDATA_W-1:0] m_tdata,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ovl_pkg::cfg_t    cfg_q;
	ovl_pkg::state_t  state_q;
	ovl_pkg::state_t  state_nxt;
	ovl_pkg::result_t res_nxt;
	ovl_pkg::result_t res_q;
	ovl_pkg::cmd_t    cmd_s1;
	logic signed [15:0] voltage_s1;
	logic        valid_s1;
	logic        out_valid_q;
	logic        advance;
	logic        cfg_wr;
	logic [2:0]  reg_idx;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_thr      <= ovl_pkg::HIGH_THR_RST;
			cfg_q.medium_thr    <= ovl_pkg::MEDIUM_THR_RST;
			cfg_q.low_thr       <= ovl_pkg::LOW_THR_RST;
			cfg_q.lockout_ticks <= ovl_pkg::LOCKOUT_RST;
			cfg_q.flash_fast    <= ovl_pkg::FLASH_FAST_RST;
			cfg_q.flash_medium  <= ovl_pkg::FLASH_MED_RST;
			cfg_q.flash_slow    <= ovl_pkg::FLASH_SLOW_RST;
			cfg_q.enable_mask   <= ovl_pkg::ENABLE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				ovl_pkg::REG_HIGH_THR:   cfg_q.high_thr      <= pwdata[15:0];
				ovl_pkg::REG_MEDIUM_THR: cfg_q.medium_thr    <= pwdata[15:0];
				ovl_pkg::REG_LOW_THR:    cfg_q.low_thr       <= pwdata[15:0];
				ovl_pkg::REG_LOCKOUT:    cfg_q.lockout_ticks <= pwdata[23:0];
				ovl_pkg::REG_FLASH_FAST: cfg_q.flash_fast    <= pwdata[15:0];
				ovl_pkg::REG_FLASH_MED:  cfg_q.flash_medium  <= pwdata[15:0];
				ovl_pkg::REG_FLASH_SLOW: cfg_q.flash_slow    <= pwdata[15:0];
				default:                 cfg_q.enable_mask   <= pwdata[2:0];
			endcase
		end
	end

	// Register read-back
	always_comb begin
		case (reg_idx)
			ovl_pkg::REG_HIGH_THR:   prdata = {{16{cfg_q.high_thr[15]}}, cfg_q.high_thr};
			ovl_pkg::REG_MEDIUM_THR: prdata = {{16{cfg_q.medium_thr[15]}}, cfg_q.medium_thr};
			ovl_pkg::REG_LOW_THR:    prdata = {{16{cfg_q.low_thr[15]}}, cfg_q.low_thr};
			ovl_pkg::REG_LOCKOUT:    prdata = {8'd0, cfg_q.lockout_ticks};
			ovl_pkg::REG_FLASH_FAST: prdata = {16'd0, cfg_q.flash_fast};
			ovl_pkg::REG_FLASH_MED:  prdata = {16'd0, cfg_q.flash_medium};
			ovl_pkg::REG_FLASH_SLOW: prdata = {16'd0, cfg_q.flash_slow};
			default:                 prdata = {29'd0, cfg_q.enable_mask};
		endcase
	end

	// Advance the pipeline when the result register is free or being drained
	assign advance  = ~out_valid_q | m_tready;
	assign s_tready = ~valid_s1 | advance;

	// Input register: hold the beat until it is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1     <= ovl_pkg::cmd_t'(s_tuser);
			voltage_s1 <= s_tdata;
		end
	end

	ovl_step u_step (
		.cfg     (cfg_q),
		.cur     (state_q),
		.cmd     (cmd_s1),
		.voltage (voltage_s1),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	// State update: commit once the beat moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode              <= ovl_pkg::MODE_SAFE;
			state_q.level             <= ovl_pkg::LVL_NONE;
			state_q.last_voltage      <= '0;
			state_q.lockout_remaining <= '0;
			state_q.danger_counter    <= '0;
			state_q.ack_flag          <= 1'b0;
			state_q.flash_active      <= 1'b0;
			state_q.flash_elapsed     <= '0;
			state_q.flash_period      <= ovl_pkg::FLASH_FAST_RST;
			state_q.led_level         <= 1'b0;
			state_q.beep_active       <= 1'b0;
			state_q.beep_elapsed      <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(ovl_pkg::TDATA_W - ovl_pkg::RESULT_W){1'b0}}, res_q};

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for overvoltage_alert_lockout_core.
// Event beats go in on the input stream, and each result beat is compared,
// field by field, with an in-bench prediction of the alarm state. Register
// writes happen only while the core is idle, and each write is read back.
// Both stream sides idle and stall at random. One stretch holds the result
// side off for a long time so that the core fills up and stalls its input.
// ---------------------------------------------------------------------------
module tb;

	localparam int PAD_W = ovl_pkg::TDATA_W - ovl_pkg::RESULT_W;

	// Alarm state as predicted from the accepted event beats
	typedef struct {
		ovl_pkg::mode_t     mode;
		logic [1:0]         lvl;
		logic signed [15:0] held;
		logic [23:0]        lock_left;
		logic [7:0]         count;
		logic               ack;
		logic               flashing;
		logic [15:0]        flash_cnt;
		logic [15:0]        flash_per;
		logic               led;
		logic               beeping;
		logic [15:0]        beep_cnt;
	} alarm_state_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [15:0]         s_tdata;   // [15:0] voltage
	logic [1:0]          s_tuser;   // [1:0] cmd
	logic                m_tvalid;
	logic                m_tready;
	// [1:0] alert_level, [3:2] safety_state, [4] ac_danger, [5] locked_out,
	// [6] can_proceed, [7] awaiting_ack, [8] red_led, [9] beep_on,
	// [17:10] danger_total, [33:18] held_voltage, [34] acknowledged
	logic [ovl_pkg::TDATA_W-1:0] m_tdata;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [4:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	ovl_pkg::cfg_t       regs;
	alarm_state_t        alarm;
	ovl_pkg::result_t    expected_results[$];
	int                  mismatches = 0;
	bit                  idle_on = 1'b1;
	int                  long_hold = 0;

	overvoltage_alert_lockout_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard limit on the run
	initial begin
		#5ms;
		$display("** overvoltage_alert_lockout_core: FAILED **");
		$finish;
	end

	// Advance the predicted alarm state by one event and return its result
	function automatic ovl_pkg::result_t predict_event(ovl_pkg::cmd_t c,
			logic signed [15:0] v);
		ovl_pkg::result_t r;
		logic [1:0]       lvl;
		logic             locked;
		case (c)
			ovl_pkg::CMD_CHECK: begin
				if (v > regs.high_thr)
					lvl = ovl_pkg::LVL_HIGH;
				else if (v > regs.medium_thr)
					lvl = ovl_pkg::LVL_MEDIUM;
				else if (v > regs.low_thr)
					lvl = ovl_pkg::LVL_LOW;
				else
					lvl = ovl_pkg::LVL_NONE;
				alarm.held = v;
				alarm.lvl  = lvl;
				if (lvl != ovl_pkg::LVL_NONE) begin
					alarm.mode = ovl_pkg::MODE_DANGER;
					if (alarm.count != 8'hFF)
						alarm.count++;
					if (regs.enable_mask[ovl_pkg::EN_LED]) begin
						alarm.flash_per = (lvl == ovl_pkg::LVL_HIGH) ? regs.flash_fast :
							(lvl == ovl_pkg::LVL_MEDIUM) ? regs.flash_medium :
							regs.flash_slow;
						alarm.flashing  = 1'b1;
						alarm.flash_cnt = '0;
						alarm.led       = 1'b1;
					end
					if (regs.enable_mask[ovl_pkg::EN_SOUND]) begin
						alarm.beeping  = 1'b1;
						alarm.beep_cnt = '0;
					end
					if (lvl == ovl_pkg::LVL_HIGH && regs.enable_mask[ovl_pkg::EN_LOCK]) begin
						alarm.mode      = ovl_pkg::MODE_LOCKOUT;
						alarm.lock_left = regs.lockout_ticks;
						alarm.count     = '0;
						alarm.flashing  = 1'b0;
						alarm.beeping   = 1'b0;
						alarm.led       = 1'b0;
					end
				end
			end
			ovl_pkg::CMD_TICK: begin
				if (alarm.flashing) begin
					alarm.flash_cnt = alarm.flash_cnt + 16'd1;
					if (alarm.flash_cnt >= alarm.flash_per) begin
						alarm.flash_cnt = '0;
						alarm.led       = ~alarm.led;
					end
				end
				if (alarm.beeping) begin
					if (alarm.beep_cnt != 16'hFFFF)
						alarm.beep_cnt++;
					if (alarm.beep_cnt >= ovl_pkg::BEEP_TICKS)
						alarm.beeping = 1'b0;
				end
				if (alarm.lock_left != '0)
					alarm.lock_left--;
			end
			ovl_pkg::CMD_ACK: begin
				alarm.ack      = 1'b1;
				alarm.flashing = 1'b0;
				alarm.beeping  = 1'b0;
				alarm.led      = 1'b0;
				if (alarm.mode == ovl_pkg::MODE_LOCKOUT)
					alarm.mode = ovl_pkg::MODE_WARNING;
			end
			default: begin
				alarm.mode      = ovl_pkg::MODE_SAFE;
				alarm.lvl       = ovl_pkg::LVL_NONE;
				alarm.held      = '0;
				alarm.lock_left = '0;
				alarm.count     = '0;
				alarm.ack       = 1'b0;
				alarm.flashing  = 1'b0;
				alarm.beeping   = 1'b0;
				alarm.led       = 1'b0;
			end
		endcase

		// Release an expired and acknowledged lockout
		if (alarm.mode == ovl_pkg::MODE_LOCKOUT && alarm.lock_left == '0 && alarm.ack) begin
			alarm.mode = ovl_pkg::MODE_SAFE;
			alarm.ack  = 1'b0;
		end

		locked         = (alarm.mode == ovl_pkg::MODE_LOCKOUT);
		r.alert_level  = alarm.lvl;
		r.safety_state = alarm.mode;
		r.ac_danger    = (alarm.held >= regs.medium_thr);
		r.locked_out   = locked;
		r.can_proceed  = !locked && !(alarm.mode == ovl_pkg::MODE_DANGER && !alarm.ack);
		r.awaiting_ack = locked && alarm.lock_left == '0 && !alarm.ack;
		r.red_led      = alarm.led;
		r.beep_on      = alarm.beeping;
		r.danger_total = alarm.count;
		r.held_voltage = alarm.held;
		r.acknowledged = alarm.ack;
		return r;
	endfunction

	function automatic string describe(ovl_pkg::result_t r);
		return $sformatf({"lvl=%0d state=%0d ac=%b lock=%b go=%b wait=%b led=%b ",
			"beep=%b count=%0d volt=%0d ack=%b"}, r.alert_level, r.safety_state,
			r.ac_danger, r.locked_out, r.can_proceed, r.awaiting_ack, r.red_led,
			r.beep_on, r.danger_total, r.held_voltage, r.acknowledged);
	endfunction

	// Offer one event beat, hold it until accepted, then record its prediction
	task automatic post_event(ovl_pkg::cmd_t c, logic [15:0] v);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(predict_event(c, v));
	endtask

	// Drop valid and wait until every predicted result has arrived
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register while idle, then read it back
	task automatic write_register(logic [2:0] idx, logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] seen;
		settle();
		case (idx)
			ovl_pkg::REG_LOCKOUT: mask = 32'h00FF_FFFF;
			ovl_pkg::REG_ENABLE:  mask = 32'h0000_0007;
			default:              mask = 32'h0000_FFFF;
		endcase
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			ovl_pkg::REG_HIGH_THR:   regs.high_thr      = value[15:0];
			ovl_pkg::REG_MEDIUM_THR: regs.medium_thr    = value[15:0];
			ovl_pkg::REG_LOW_THR:    regs.low_thr       = value[15:0];
			ovl_pkg::REG_LOCKOUT:    regs.lockout_ticks = value[23:0];
			ovl_pkg::REG_FLASH_FAST: regs.flash_fast    = value[15:0];
			ovl_pkg::REG_FLASH_MED:  regs.flash_medium  = value[15:0];
			ovl_pkg::REG_FLASH_SLOW: regs.flash_slow    = value[15:0];
			default:                 regs.enable_mask   = value[2:0];
		endcase
		// read back
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		seen = prdata;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if ((seen & mask) !== (value & mask)) begin
			mismatches++;
			if (mismatches <= 10)
				$display("register %0d read back %h, expected %h", idx, seen & mask,
					value & mask);
		end
	endtask

	// Voltages mostly around the thresholds, where the grading changes
	function automatic logic [15:0] pick_voltage();
		int t;
		case ($urandom_range(0, 4))
			0:       t = $urandom;
			1:       t = int'(regs.high_thr) + int'($urandom_range(0, 4)) - 2;
			2:       t = int'(regs.medium_thr) + int'($urandom_range(0, 4)) - 2;
			3:       t = int'(regs.low_thr) + int'($urandom_range(0, 4)) - 2;
			default: t = int'(regs.high_thr) + 1 + int'($urandom_range(0, 200));
		endcase
		return t[15:0];
	endfunction

	task automatic run_random_events(int count);
		int            r;
		ovl_pkg::cmd_t c;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				c = ovl_pkg::CMD_TICK;
			else if (r < 78)
				c = ovl_pkg::CMD_CHECK;
			else if (r < 95)
				c = ovl_pkg::CMD_ACK;
			else
				c = ovl_pkg::CMD_RESET;
			post_event(c, pick_voltage());
		end
	endtask

	// Draw a fresh register setting with short timers
	task automatic shuffle_registers(bit ordered);
		int lo, md, hi;
		if (ordered) begin
			lo = int'($urandom_range(0, 2000)) - 1000;
			md = lo + int'($urandom_range(0, 300));
			hi = md + int'($urandom_range(0, 300));
		end else begin
			lo = $urandom;
			md = $urandom;
			hi = $urandom;
		end
		write_register(ovl_pkg::REG_HIGH_THR, 32'(hi) & 32'hFFFF);
		write_register(ovl_pkg::REG_MEDIUM_THR, 32'(md) & 32'hFFFF);
		write_register(ovl_pkg::REG_LOW_THR, 32'(lo) & 32'hFFFF);
		write_register(ovl_pkg::REG_LOCKOUT, $urandom_range(0, 15));
		write_register(ovl_pkg::REG_FLASH_FAST, $urandom_range(0, 6));
		write_register(ovl_pkg::REG_FLASH_MED, $urandom_range(0, 6));
		write_register(ovl_pkg::REG_FLASH_SLOW, $urandom_range(0, 6));
		write_register(ovl_pkg::REG_ENABLE, {29'd0, ($urandom_range(0, 3) != 0),
			2'($urandom_range(0, 3))});
	endtask

	// Grading at default thresholds, lockout entry and acknowledge
	task automatic test_levels_and_lockout();
		post_event(ovl_pkg::CMD_CHECK, 16'd0);
		post_event(ovl_pkg::CMD_CHECK, 16'd1301);
		post_event(ovl_pkg::CMD_CHECK, 16'd1500);
		post_event(ovl_pkg::CMD_CHECK, 16'd1501);
		post_event(ovl_pkg::CMD_CHECK, 16'd2000);
		post_event(ovl_pkg::CMD_TICK, 16'hFFFF);
		post_event(ovl_pkg::CMD_CHECK, 16'd2001);
		post_event(ovl_pkg::CMD_TICK, 16'h0000);
		post_event(ovl_pkg::CMD_ACK, 16'h5A5A);
		post_event(ovl_pkg::CMD_CHECK, 16'h8000);
		post_event(ovl_pkg::CMD_CHECK, 16'h7FFF);
		post_event(ovl_pkg::CMD_RESET, 16'hA5A5);
		post_event(ovl_pkg::CMD_ACK, 16'd0);
		post_event(ovl_pkg::CMD_CHECK, 16'd1400);
	endtask

	// All alerts off, then sound, LED and automatic lockout each switched on alone
	task automatic test_alert_enables();
		write_register(ovl_pkg::REG_ENABLE, 32'd0);
		post_event(ovl_pkg::CMD_RESET, 16'd0);
		post_event(ovl_pkg::CMD_CHECK, 16'd2100);
		post_event(ovl_pkg::CMD_CHECK, 16'd1400);
		write_register(ovl_pkg::REG_ENABLE, 32'd1 << ovl_pkg::EN_SOUND);
		post_event(ovl_pkg::CMD_CHECK, 16'd1600);
		write_register(ovl_pkg::REG_ENABLE, 32'd1 << ovl_pkg::EN_LED);
		post_event(ovl_pkg::CMD_CHECK, 16'd2100);
		post_event(ovl_pkg::CMD_TICK, 16'd0);
		write_register(ovl_pkg::REG_ENABLE, 32'd1 << ovl_pkg::EN_LOCK);
		post_event(ovl_pkg::CMD_CHECK, 16'd2100);
	endtask

	// Zero flash periods toggle every tick; zero lockout time expires at once
	task automatic test_zero_periods();
		write_register(ovl_pkg::REG_ENABLE, 32'd7);
		write_register(ovl_pkg::REG_LOCKOUT, 32'd0);
		write_register(ovl_pkg::REG_FLASH_FAST, 32'd0);
		write_register(ovl_pkg::REG_FLASH_MED, 32'd0);
		write_register(ovl_pkg::REG_FLASH_SLOW, 32'd0);
		post_event(ovl_pkg::CMD_RESET, 16'd0);
		post_event(ovl_pkg::CMD_CHECK, 16'd1600);
		post_event(ovl_pkg::CMD_TICK, 16'd0);
		post_event(ovl_pkg::CMD_TICK, 16'd0);
		post_event(ovl_pkg::CMD_ACK, 16'd0);
		post_event(ovl_pkg::CMD_CHECK, 16'd2100);
		post_event(ovl_pkg::CMD_CHECK, 16'd2100);
		post_event(ovl_pkg::CMD_TICK, 16'd0);
		post_event(ovl_pkg::CMD_ACK, 16'd0);
		post_event(ovl_pkg::CMD_CHECK, 16'd1400);
	endtask

	// Thresholds, timers and periods at the ends of their ranges
	task automatic test_register_extremes();
		write_register(ovl_pkg::REG_HIGH_THR, 32'h7FFF);
		write_register(ovl_pkg::REG_MEDIUM_THR, 32'h8000);
		write_register(ovl_pkg::REG_LOW_THR, 32'h8000);
		write_register(ovl_pkg::REG_LOCKOUT, 32'hFF_FFFF);
		write_register(ovl_pkg::REG_FLASH_FAST, 32'hFFFF);
		write_register(ovl_pkg::REG_FLASH_MED, 32'hFFFF);
		write_register(ovl_pkg::REG_FLASH_SLOW, 32'hFFFF);
		write_register(ovl_pkg::REG_ENABLE, 32'd7);
		post_event(ovl_pkg::CMD_CHECK, 16'h7FFF);
		post_event(ovl_pkg::CMD_CHECK, 16'h8000);
		write_register(ovl_pkg::REG_HIGH_THR, 32'h8000);
		write_register(ovl_pkg::REG_MEDIUM_THR, 32'h7FFF);
		write_register(ovl_pkg::REG_LOW_THR, 32'h7FFF);
		post_event(ovl_pkg::CMD_CHECK, 16'h8001);
		post_event(ovl_pkg::CMD_TICK, 16'd0);
		post_event(ovl_pkg::CMD_ACK, 16'd0);
		post_event(ovl_pkg::CMD_CHECK, 16'h7FFF);
		post_event(ovl_pkg::CMD_TICK, 16'd0);
	endtask

	// Danger count holds at its ceiling
	task automatic test_count_saturation();
		write_register(ovl_pkg::REG_HIGH_THR, 32'd2000);
		write_register(ovl_pkg::REG_MEDIUM_THR, 32'd1500);
		write_register(ovl_pkg::REG_LOW_THR, 32'd1300);
		write_register(ovl_pkg::REG_ENABLE,
			(32'd1 << ovl_pkg::EN_SOUND) | (32'd1 << ovl_pkg::EN_LED));
		post_event(ovl_pkg::CMD_RESET, 16'd0);
		repeat (260)
			post_event(ovl_pkg::CMD_CHECK, 16'(1301 + $urandom_range(0, 699)));
	endtask

	// Beep runs out after its fixed length while the LED keeps flashing
	task automatic test_beep_expiry();
		write_register(ovl_pkg::REG_FLASH_MED, 32'd7);
		post_event(ovl_pkg::CMD_RESET, 16'd0);
		post_event(ovl_pkg::CMD_CHECK, 16'd1600);
		repeat (505)
			post_event(ovl_pkg::CMD_TICK, 16'($urandom));
	endtask

	// Hold the result side off so the core stalls its input, then drain
	task automatic test_backpressure();
		write_register(ovl_pkg::REG_ENABLE, 32'd7);
		write_register(ovl_pkg::REG_LOCKOUT, 32'd5);
		long_hold = 60;
		idle_on   = 1'b0;
		run_random_events(24);
		idle_on   = 1'b1;
		settle();
	endtask

	// Random events over several register settings
	task automatic test_random_phases();
		shuffle_registers(1'b1);
		run_random_events(100);
		shuffle_registers(1'b1);
		idle_on = 1'b0;
		run_random_events(100);
		idle_on = 1'b1;
		shuffle_registers(1'b0);
		run_random_events(100);
		shuffle_registers(1'b1);
		run_random_events(100);
	endtask

	// Result sink: random stalls per beat, plus a long hold when asked
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall     = long_hold + (idle_on ? $urandom_range(0, 3) : 0);
			long_hold = 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready) && long_hold == 0);
		end
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin : result_check
		ovl_pkg::result_t got;
		ovl_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = ovl_pkg::result_t'(m_tdata[ovl_pkg::RESULT_W-1:0]);
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat with nothing expected: %s", describe(got));
			end else begin
				want = expected_results.pop_front();
				if (got !== want ||
						m_tdata[ovl_pkg::TDATA_W-1:ovl_pkg::TDATA_W-PAD_W] !== '0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result mismatch at %0t ns", $realtime);
						$display("  expected %s", describe(want));
						$display("  actual   %s pad=%h", describe(got),
							m_tdata[ovl_pkg::TDATA_W-1:ovl_pkg::TDATA_W-PAD_W]);
					end
				end
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ovl_pkg::CMD_CHECK;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;

		regs = '{high_thr: ovl_pkg::HIGH_THR_RST, medium_thr: ovl_pkg::MEDIUM_THR_RST,
			low_thr: ovl_pkg::LOW_THR_RST, lockout_ticks: ovl_pkg::LOCKOUT_RST,
			flash_fast: ovl_pkg::FLASH_FAST_RST, flash_medium: ovl_pkg::FLASH_MED_RST,
			flash_slow: ovl_pkg::FLASH_SLOW_RST, enable_mask: ovl_pkg::ENABLE_RST};
		alarm = '{mode: ovl_pkg::MODE_SAFE, lvl: ovl_pkg::LVL_NONE, held: '0,
			lock_left: '0, count: '0, ack: 1'b0, flashing: 1'b0, flash_cnt: '0,
			flash_per: ovl_pkg::FLASH_FAST_RST, led: 1'b0, beeping: 1'b0,
			beep_cnt: '0};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_levels_and_lockout();
		test_alert_enables();
		test_zero_periods();
		test_register_extremes();
		test_count_saturation();
		test_beep_expiry();
		test_backpressure();
		test_random_phases();
		settle();
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("** overvoltage_alert_lockout_core: PASSED **");
		else
			$display("** overvoltage_alert_lockout_core: FAILED **");
		$finish;
	end

endmodule
